// ===== rtl/core/evidence_grid_ray_update_assert.svh =====
// Assertion macros for the evidence grid ray update block.
`ifndef EVIDENCE_GRID_RAY_UPDATE_ASSERT_SVH
`define EVIDENCE_GRID_RAY_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define EGR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("egr assertion failed");
`define EGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("egr assertion failed");
`else
`define EGR_ASSERT_NOW(label, ante, cons)
`define EGR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/egr_pkg.sv =====
// Shared types and constants of the evidence grid ray update block.
`default_nettype none

package egr_pkg;

    localparam int GRID_WIDTH_DEF  = 512;
    localparam int GRID_HEIGHT_DEF = 512;

    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_EMPTY_STEP = 2'd0;
    localparam logic [1:0] REG_FILL_STEP  = 2'd1;
    localparam logic [1:0] REG_LIMIT      = 2'd2;
    localparam logic [1:0] REG_PRIOR      = 2'd3;

    localparam logic [5:0] EMPTY_STEP_RST = 6'd2;
    localparam logic [5:0] FILL_STEP_RST  = 6'd2;
    localparam logic [6:0] LIMIT_RST      = 7'd100;
    localparam logic [7:0] PRIOR_RST      = 8'd0;

    localparam logic [7:0] UNKNOWN_CODE = 8'h80;

    typedef enum logic [1:0] {
        CMP_GE = 2'd0,
        CMP_LE = 2'd1,
        CMP_GT = 2'd2
    } egr_cmp_t;

    typedef struct packed {
        logic              major_x;
        logic              major_inc;
        logic              minor_inc;
        egr_cmp_t          cmp;
        logic signed [13:0] a;
        logic signed [13:0] b;
        logic signed [13:0] t;
    } egr_walk_t;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [14:0] eps;
    } egr_pos_t;

    typedef struct packed {
        logic              func;
        logic              mark_filled;
        logic signed [11:0] start_x;
        logic signed [11:0] start_y;
        logic signed [11:0] end_x;
        logic signed [11:0] end_y;
    } egr_ray_t;

    typedef struct packed {
        logic signed [7:0] cell_value;
        logic              cell_known;
        logic [12:0]       cells_written;
        logic              clipped;
    } egr_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/evidence_grid_ray_update.sv =====
// Top level of the evidence grid ray update block: sequencer, grid memory and registers.
// A ray item visits each cell along its line: an in-grid cell is read in S_VISIT and
// updated in S_WRITE, an off-grid cell is skipped and the result marked clipped; a read
// item reads its cell, or reports it unknown and clipped when it lies off the grid.
// One item is handled at a time: a new item is stalled until the last result is taken.
// After reset a clearing pass marks every cell unknown; items wait until it ends,
// while register writes are taken throughout.
`default_nettype none

`include "evidence_grid_ray_update_assert.svh"

module evidence_grid_ray_update
    import egr_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  ray_valid,
    output logic                       ray_stall,
    input  wire egr_ray_t              ray_data,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output egr_res_t                   res_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_VISIT  = 6'b000100,
        S_WRITE  = 6'b001000,
        S_RDCELL = 6'b010000,
        S_DONE   = 6'b100000
    } egr_state_t;

    egr_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [5:0]        empty_reg, empty_next;
    logic [5:0]        fill_reg, fill_next;
    logic [6:0]        limit_reg, limit_next;
    logic [7:0]        prior_reg, prior_next;

    egr_pos_t          pos_reg, pos_next;
    egr_walk_t         walk_reg, walk_next;
    logic [11:0]       left_reg, left_next;
    logic [12:0]       count_reg, count_next;
    logic              clip_reg, clip_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              func_reg, func_next;
    logic              mark_reg, mark_next;
    egr_res_t          res_reg, res_next;
    logic [7:0]        mem_q_reg;

    logic [7:0]        grid_mem [DEPTH];

    egr_walk_t         walk_init;
    logic [11:0]       major_len;
    egr_pos_t          pos_step;
    logic [7:0]        cell_code;

    logic              cfg_we;
    logic              x_ok;
    logic              y_ok;
    logic              in_grid;
    logic [ADDR_W-1:0] cell_addr;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    egr_step u_step (
        .ray       (ray_data),
        .walk_init (walk_init),
        .major_len (major_len),
        .walk      (walk_reg),
        .pos       (pos_reg),
        .pos_step  (pos_step)
    );

    egr_cell u_cell (
        .code           (mem_q_reg),
        .mark_filled    (mark_reg),
        .empty_step     (empty_reg),
        .fill_step      (fill_reg),
        .evidence_limit (limit_reg),
        .prior_value    (prior_reg),
        .code_next      (cell_code)
    );

    assign x_ok      = !pos_reg.x[11] && ({1'b0, pos_reg.x} < 13'(GRID_WIDTH));
    assign y_ok      = !pos_reg.y[11] && ({1'b0, pos_reg.y} < 13'(GRID_HEIGHT));
    assign in_grid   = x_ok && y_ok;
    assign cell_addr = ADDR_W'(pos_reg.x[XW-1:0]) * ADDR_W'(GRID_HEIGHT)
                     + ADDR_W'(pos_reg.y[YW-1:0]);

    assign cfg_we    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign ray_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = res_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_EMPTY_STEP: prdata = {26'b0, empty_reg};
            REG_FILL_STEP:  prdata = {26'b0, fill_reg};
            REG_LIMIT:      prdata = {25'b0, limit_reg};
            REG_PRIOR:      prdata = {24'b0, prior_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        empty_next = empty_reg;
        fill_next  = fill_reg;
        limit_next = limit_reg;
        prior_next = prior_reg;
        if (cfg_we)
        begin
            case (paddr[3:2])
                REG_EMPTY_STEP: empty_next = pwdata[5:0];
                REG_FILL_STEP:  fill_next  = pwdata[5:0];
                REG_LIMIT:      limit_next = pwdata[6:0];
                REG_PRIOR:      prior_next = pwdata[7:0];
                default:        empty_next = empty_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        walk_next  = walk_reg;
        left_next  = left_reg;
        count_next = count_reg;
        clip_next  = clip_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        mark_next  = mark_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = UNKNOWN_CODE;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (ray_valid)
                begin
                    pos_next   = '{x: ray_data.start_x, y: ray_data.start_y, eps: '0};
                    walk_next  = walk_init;
                    left_next  = major_len;
                    count_next = '0;
                    clip_next  = 1'b0;
                    func_next  = ray_data.func;
                    mark_next  = ray_data.mark_filled;
                    state_next = S_VISIT;
                end
            end
            S_VISIT:
            begin
                if (in_grid)
                begin
                    mem_re     = 1'b1;
                    addr_next  = cell_addr;
                    state_next = func_reg ? S_RDCELL : S_WRITE;
                end
                else if (func_reg)
                begin
                    res_next   = '{cell_value: UNKNOWN_CODE, cell_known: 1'b0,
                                   cells_written: '0, clipped: 1'b1};
                    state_next = S_DONE;
                end
                else
                begin
                    clip_next = 1'b1;
                    pos_next  = pos_step;
                    left_next = left_reg - 1'b1;
                    if (left_reg == '0)
                    begin
                        res_next   = '{cell_value: '0, cell_known: 1'b0,
                                       cells_written: count_reg, clipped: 1'b1};
                        state_next = S_DONE;
                    end
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                wr_addr    = addr_reg;
                wr_data    = cell_code;
                count_next = count_reg + 1'b1;
                pos_next   = pos_step;
                left_next  = left_reg - 1'b1;
                if (left_reg == '0)
                begin
                    res_next   = '{cell_value: '0, cell_known: 1'b0,
                                   cells_written: count_reg + 1'b1, clipped: clip_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_VISIT;
                end
            end
            S_RDCELL:
            begin
                res_next   = '{cell_value: mem_q_reg, cell_known: (mem_q_reg != UNKNOWN_CODE),
                               cells_written: '0, clipped: 1'b0};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            empty_reg <= EMPTY_STEP_RST;
            fill_reg  <= FILL_STEP_RST;
            limit_reg <= LIMIT_RST;
            prior_reg <= PRIOR_RST;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            empty_reg <= empty_next;
            fill_reg  <= fill_next;
            limit_reg <= limit_next;
            prior_reg <= prior_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        walk_reg  <= walk_next;
        left_reg  <= left_next;
        count_reg <= count_next;
        clip_reg  <= clip_next;
        addr_reg  <= addr_next;
        func_reg  <= func_next;
        mark_reg  <= mark_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            mem_q_reg <= grid_mem[cell_addr];
        end
    end

    `EGR_ASSERT_NEXT(a_busy_after_accept, ray_valid && !ray_stall, ray_stall)
    `EGR_ASSERT_NOW(a_clear_blocks, state_reg == S_CLEAR, ray_stall && !res_valid)
    `EGR_ASSERT_NOW(a_read_fields, res_valid && res_data.cell_known,
                    (res_data.cells_written == 13'd0) && !res_data.clipped)
    `EGR_ASSERT_NOW(a_no_write_on_read, mem_we, !func_reg || (state_reg == S_CLEAR))

endmodule

`default_nettype wire

// ===== rtl/core/egr_step.sv =====
// Line walk unit: octant setup of a ray and one step of the error term.
`default_nettype none

module egr_step
    import egr_pkg::*;
(
    input  egr_ray_t    ray,
    output egr_walk_t   walk_init,
    output logic [11:0] major_len,
    input  egr_walk_t   walk,
    input  egr_pos_t    pos,
    output egr_pos_t    pos_step
);

    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [12:0] ndx;
    logic signed [12:0] ndy;
    logic signed [13:0] dx_w;
    logic signed [13:0] dy_w;
    logic signed [13:0] ndx_w;
    logic signed [13:0] ndy_w;

    assign dx    = {ray.end_x[11], ray.end_x} - {ray.start_x[11], ray.start_x};
    assign dy    = {ray.end_y[11], ray.end_y} - {ray.start_y[11], ray.start_y};
    assign ndx   = -dx;
    assign ndy   = -dy;
    assign dx_w  = {dx[12], dx};
    assign dy_w  = {dy[12], dy};
    assign ndx_w = {ndx[12], ndx};
    assign ndy_w = {ndy[12], ndy};

    always_comb
    begin
        walk_init = '0;
        major_len = '0;
        if (dx > 13'sd0)
        begin
            if (dy >= 13'sd0)
            begin
                if (dx > dy)
                begin
                    walk_init = '{major_x: 1'b1, major_inc: 1'b1, minor_inc: 1'b1,
                                  cmp: CMP_GE, a: dy_w, b: ndx_w, t: dx_w};
                    major_len = dx[11:0];
                end
                else
                begin
                    walk_init = '{major_x: 1'b0, major_inc: 1'b1, minor_inc: 1'b1,
                                  cmp: CMP_GE, a: dx_w, b: ndy_w, t: dy_w};
                    major_len = dy[11:0];
                end
            end
            else
            begin
                if (dx > ndy)
                begin
                    walk_init = '{major_x: 1'b1, major_inc: 1'b1, minor_inc: 1'b0,
                                  cmp: CMP_LE, a: dy_w, b: dx_w, t: ndx_w};
                    major_len = dx[11:0];
                end
                else
                begin
                    walk_init = '{major_x: 1'b0, major_inc: 1'b0, minor_inc: 1'b1,
                                  cmp: CMP_GE, a: dx_w, b: dy_w, t: ndy_w};
                    major_len = ndy[11:0];
                end
            end
        end
        else
        begin
            if (dy >= 13'sd0)
            begin
                if (ndx > dy)
                begin
                    walk_init = '{major_x: 1'b1, major_inc: 1'b0, minor_inc: 1'b1,
                                  cmp: CMP_GE, a: dy_w, b: dx_w, t: ndx_w};
                    major_len = ndx[11:0];
                end
                else
                begin
                    walk_init = '{major_x: 1'b0, major_inc: 1'b1, minor_inc: 1'b0,
                                  cmp: CMP_LE, a: dx_w, b: dy_w, t: ndy_w};
                    major_len = dy[11:0];
                end
            end
            else
            begin
                if (ndx > ndy)
                begin
                    walk_init = '{major_x: 1'b1, major_inc: 1'b0, minor_inc: 1'b0,
                                  cmp: CMP_GT, a: ndy_w, b: dx_w, t: ndx_w};
                    major_len = ndx[11:0];
                end
                else
                begin
                    walk_init = '{major_x: 1'b0, major_inc: 1'b0, minor_inc: 1'b0,
                                  cmp: CMP_GT, a: ndx_w, b: dy_w, t: ndy_w};
                    major_len = ndy[11:0];
                end
            end
        end
    end

    logic signed [14:0] eps_sum;
    logic signed [15:0] eps_dbl;
    logic signed [15:0] thr;
    logic               hit;
    logic signed [11:0] major_new;
    logic signed [11:0] minor_old;
    logic signed [11:0] minor_new;

    assign eps_sum = pos.eps + {walk.a[13], walk.a};
    assign eps_dbl = {eps_sum, 1'b0};
    assign thr     = {{2{walk.t[13]}}, walk.t};

    always_comb
    begin
        case (walk.cmp)
            CMP_GE:  hit = (eps_dbl >= thr);
            CMP_LE:  hit = (eps_dbl <= thr);
            CMP_GT:  hit = (eps_dbl > thr);
            default: hit = 1'b0;
        endcase
    end

    assign minor_old = walk.major_x ? pos.y : pos.x;

    always_comb
    begin
        if (walk.major_x)
        begin
            major_new = walk.major_inc ? pos.x + 12'sd1 : pos.x - 12'sd1;
        end
        else
        begin
            major_new = walk.major_inc ? pos.y + 12'sd1 : pos.y - 12'sd1;
        end
        if (hit)
        begin
            minor_new = walk.minor_inc ? minor_old + 12'sd1 : minor_old - 12'sd1;
        end
        else
        begin
            minor_new = minor_old;
        end
        pos_step.eps = hit ? eps_sum + {walk.b[13], walk.b} : eps_sum;
        pos_step.x   = walk.major_x ? major_new : minor_new;
        pos_step.y   = walk.major_x ? minor_new : major_new;
    end

endmodule

`default_nettype wire

// ===== rtl/core/egr_cell.sv =====
// Cell update unit: prior for unknown cells, step and clamp for known cells.
`default_nettype none

module egr_cell
    import egr_pkg::*;
(
    input  logic [7:0] code,
    input  logic       mark_filled,
    input  logic [5:0] empty_step,
    input  logic [5:0] fill_step,
    input  logic [6:0] evidence_limit,
    input  logic [7:0] prior_value,
    output logic [7:0] code_next
);

    logic signed [9:0] value;
    logic signed [9:0] sum;
    logic signed [9:0] lim_pos;
    logic signed [9:0] lim_neg;
    logic signed [9:0] clamped;

    assign value   = {{2{code[7]}}, code};
    assign sum     = mark_filled ? value + {4'b0, fill_step} : value - {4'b0, empty_step};
    assign lim_pos = {3'b0, evidence_limit};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (sum > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (sum < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = sum;
        end
        code_next = (code == UNKNOWN_CODE) ? prior_value : clamped[7:0];
    end

endmodule

`default_nettype wire
